// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge, disabled during reset.
`define CHECK_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("implication check failed");
`endif

// ===== hw/rtl/smf_pkg.sv =====
// Package for the MIDI track parser: phase encoding, event kinds and error codes.
// No dependencies.
package smf_pkg;
   typedef enum logic [3:0] {
      PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SKIP, PH_SKIP_BAD, PH_DLEN,
      PH_MLEN, PH_TEMPO, PH_TS_NUM, PH_TS_DEN, PH_TS_REST, PH_KS_SIG, PH_KS_MAJ
   } phase_type;

   localparam logic [3:0] KIND_NONE     = 4'd0;
   localparam logic [3:0] KIND_NOTE_OFF = 4'd1;
   localparam logic [3:0] KIND_NOTE_ON  = 4'd2;
   localparam logic [3:0] KIND_POLY     = 4'd3;
   localparam logic [3:0] KIND_PROGRAM  = 4'd4;
   localparam logic [3:0] KIND_CONTROL  = 4'd5;
   localparam logic [3:0] KIND_CHAN_PR  = 4'd6;
   localparam logic [3:0] KIND_BEND     = 4'd7;
   localparam logic [3:0] KIND_TEMPO    = 4'd8;
   localparam logic [3:0] KIND_TIMESIG  = 4'd9;
   localparam logic [3:0] KIND_KEYSIG   = 4'd10;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_CORRUPT = 2'd1;
   localparam logic [1:0] ERR_LENGTH  = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN = 2'd3;

   localparam logic [6:0] TEXT_LIMIT = 7'd100;
endpackage

// ===== hw/rtl/smf_track_event_parser_top.sv =====
// Top level of the MIDI track body parser.
// Depends on smf_pkg.
//
// The block takes one track body byte per word on the req_ channel and gives
// at most one result word per byte on the rsp_ channel: a finished event, the
// first error, or the end of track. A byte is parsed with a single pass
// of logic into the output register, so a new byte can be taken every
// cycle unless stalled, one byte per cycle; a result appears in the cycle
// after its byte. The output register is the only buffer: req_stall is
// raised only while a result sits in it and the result side stalls. Writing
// csr_track_length restarts the parser and loads the byte count; write it
// only while the block is idle. After the last byte or after an error, bytes
// are taken and dropped without results.
module smf_track_event_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [31:0] rsp_delta_time,
   output logic [3:0]  rsp_channel,
   output logic [23:0] rsp_value_a,
   output logic [7:0]  rsp_value_b,
   output logic signed [3:0] rsp_key_sharps,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_track_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_track_length
);
   smf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  status_ff, status_in;
   logic [31:0] delta_ff, delta_in;
   logic [31:0] vl_ff, vl_in;
   logic [2:0]  vlcnt_ff, vlcnt_in;
   logic [6:0]  skip_ff, skip_in;
   logic [7:0]  meta_ff, meta_in;
   logic [23:0] gath_ff, gath_in;
   logic [31:0] left_ff, left_in;
   logic        failed_ff, failed_in;

   logic        ov_ff, ov_in;
   logic [3:0]  okind_ff, okind_in;
   logic [31:0] odelta_ff, odelta_in;
   logic [3:0]  ochan_ff, ochan_in;
   logic [23:0] oa_ff, oa_in;
   logic [7:0]  ob_ff, ob_in;
   logic [3:0]  okey_ff, okey_in;
   logic [1:0]  oerr_ff, oerr_in;
   logic        odone_ff, odone_in;

   logic take;
   logic [7:0] b;
   logic [31:0] vl_next;
   logic [2:0]  vl_cnt_next;
   logic        vl_end;
   logic [31:0] left_dec;
   logic        last;
   logic        give;
   logic [7:0]  ksig;

   // Input is held back only when the output register is full and stalled.
   assign req_stall = ov_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign b         = req_data_byte;

   assign vl_next     = {vl_ff[24:0], b[6:0]};
   assign vl_cnt_next = vlcnt_ff + 3'd1;
   assign vl_end      = ~b[7];
   assign left_dec    = left_ff - 32'd1;
   assign last        = (left_dec == 32'd0);
   assign ksig        = gath_ff[7:0];

   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      delta_in  = delta_ff;
      vl_in     = vl_ff;
      vlcnt_in  = vlcnt_ff;
      skip_in   = skip_ff;
      meta_in   = meta_ff;
      gath_in   = gath_ff;
      left_in   = left_ff;
      failed_in = failed_ff;
      okind_in  = smf_pkg::KIND_NONE;
      ochan_in  = 4'd0;
      oa_in     = 24'd0;
      ob_in     = 8'd0;
      okey_in   = 4'd0;
      oerr_in   = smf_pkg::ERR_NONE;
      give      = 1'b0;

      if (take && !failed_ff && left_ff != 32'd0) begin
         // Small helper effects are written inline; give() zeroes the sum and
         // returns to delta parsing.
         case (phase_ff)
            smf_pkg::PH_DELTA, smf_pkg::PH_MLEN: begin
               vl_in    = vl_next;
               vlcnt_in = vl_cnt_next;
               if (!vl_end) begin
                  if (vl_cnt_next >= 3'd5) begin
                     oerr_in   = smf_pkg::ERR_LENGTH;
                     failed_in = 1'b1;
                  end
               end else begin
                  vl_in    = 32'd0;
                  vlcnt_in = 3'd0;
                  if (phase_ff == smf_pkg::PH_DELTA) begin
                     delta_in = delta_ff + vl_next;
                     phase_in = smf_pkg::PH_STATUS;
                  end else begin
                     case (meta_ff)
                        8'h2F: phase_in = smf_pkg::PH_DELTA;
                        8'h51: begin
                           if (vl_next != 32'd3) begin
                              oerr_in = smf_pkg::ERR_CORRUPT; failed_in = 1'b1;
                           end else begin
                              gath_in = 24'd0; skip_in = 7'd3;
                              phase_in = smf_pkg::PH_TEMPO;
                           end
                        end
                        8'h58: begin
                           if (vl_next != 32'd4) begin
                              oerr_in = smf_pkg::ERR_CORRUPT; failed_in = 1'b1;
                           end else phase_in = smf_pkg::PH_TS_NUM;
                        end
                        8'h59: begin
                           if (vl_next != 32'd2) begin
                              oerr_in = smf_pkg::ERR_CORRUPT; failed_in = 1'b1;
                           end else phase_in = smf_pkg::PH_KS_SIG;
                        end
                        default: begin
                           if (vl_next >= {25'd0, smf_pkg::TEXT_LIMIT}) begin
                              oerr_in = smf_pkg::ERR_LENGTH; failed_in = 1'b1;
                           end else if (vl_next == 32'd0) begin
                              phase_in = smf_pkg::PH_DELTA;
                           end else begin
                              skip_in  = vl_next[6:0];
                              phase_in = smf_pkg::PH_SKIP;
                           end
                        end
                     endcase
                  end
               end
            end
            smf_pkg::PH_STATUS, smf_pkg::PH_DATA1: begin
               if (phase_ff == smf_pkg::PH_STATUS && b[7]) begin
                  status_in = b;
                  phase_in  = smf_pkg::PH_DATA1;
               end else begin
                  case (status_ff[7:4])
                     4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
                        gath_in  = {16'd0, b};
                        phase_in = smf_pkg::PH_DATA2;
                     end
                     4'hC, 4'hD: begin
                        give     = 1'b1;
                        okind_in = (status_ff[7:4] == 4'hC) ? smf_pkg::KIND_PROGRAM
                                                            : smf_pkg::KIND_CHAN_PR;
                        ochan_in = status_ff[3:0];
                        oa_in    = {16'd0, b};
                     end
                     4'hF: begin
                        status_in = 8'd0;
                        if (status_ff == 8'hFF) begin
                           meta_in = b;
                           if (b == 8'h00 || b == 8'h20 || b == 8'h21) begin
                              phase_in = smf_pkg::PH_DLEN;
                           end else begin
                              vl_in = 32'd0; vlcnt_in = 3'd0;
                              phase_in = smf_pkg::PH_MLEN;
                           end
                        end else if (b >= 8'd127) begin
                           oerr_in = smf_pkg::ERR_CORRUPT; failed_in = 1'b1;
                        end else if (b == 8'd0) begin
                           phase_in = smf_pkg::PH_DELTA;
                           if (status_ff != 8'hF0 && status_ff != 8'hF7) begin
                              oerr_in = smf_pkg::ERR_UNKNOWN; failed_in = 1'b1;
                           end
                        end else begin
                           skip_in  = b[6:0];
                           phase_in = (status_ff == 8'hF0 || status_ff == 8'hF7)
                                      ? smf_pkg::PH_SKIP : smf_pkg::PH_SKIP_BAD;
                        end
                     end
                     default: phase_in = smf_pkg::PH_DELTA;
                  endcase
               end
            end
            smf_pkg::PH_DATA2: begin
               ochan_in = status_ff[3:0];
               oa_in    = {16'd0, gath_ff[7:0]};
               ob_in    = b;
               give     = 1'b1;
               case (status_ff[7:4])
                  4'h8: okind_in = smf_pkg::KIND_NOTE_OFF;
                  4'h9: okind_in = (b != 8'd0) ? smf_pkg::KIND_NOTE_ON
                                               : smf_pkg::KIND_NOTE_OFF;
                  4'hA: okind_in = smf_pkg::KIND_POLY;
                  4'hB: okind_in = smf_pkg::KIND_CONTROL;
                  4'hE: okind_in = smf_pkg::KIND_BEND;
                  default: begin
                     give = 1'b0; ochan_in = 4'd0; oa_in = 24'd0; ob_in = 8'd0;
                     phase_in = smf_pkg::PH_DELTA;
                  end
               endcase
            end
            smf_pkg::PH_SKIP, smf_pkg::PH_SKIP_BAD: begin
               skip_in = skip_ff - 7'd1;
               if (skip_ff == 7'd1) begin
                  phase_in = smf_pkg::PH_DELTA;
                  if (phase_ff == smf_pkg::PH_SKIP_BAD) begin
                     oerr_in = smf_pkg::ERR_UNKNOWN; failed_in = 1'b1;
                  end
               end
            end
            smf_pkg::PH_DLEN: begin
               if (b != ((meta_ff == 8'h00) ? 8'd2 : 8'd1)) begin
                  oerr_in = smf_pkg::ERR_CORRUPT; failed_in = 1'b1;
               end else begin
                  skip_in  = (meta_ff == 8'h00) ? 7'd2 : 7'd1;
                  phase_in = smf_pkg::PH_SKIP;
               end
            end
            smf_pkg::PH_TEMPO: begin
               gath_in = {gath_ff[15:0], b};
               skip_in = skip_ff - 7'd1;
               if (skip_ff == 7'd1) begin
                  give = 1'b1; okind_in = smf_pkg::KIND_TEMPO;
                  oa_in = {gath_ff[15:0], b};
               end
            end
            smf_pkg::PH_TS_NUM: begin
               gath_in = {16'd0, b}; phase_in = smf_pkg::PH_TS_DEN;
            end
            smf_pkg::PH_TS_DEN: begin
               if (b >= 8'd5 || gath_ff[7:0] > 8'd20) begin
                  oerr_in = smf_pkg::ERR_CORRUPT; failed_in = 1'b1;
               end else begin
                  gath_in = {8'd0, gath_ff[7:0], b};
                  skip_in = 7'd2; phase_in = smf_pkg::PH_TS_REST;
               end
            end
            smf_pkg::PH_TS_REST: begin
               skip_in = skip_ff - 7'd1;
               if (skip_ff == 7'd1) begin
                  give = 1'b1; okind_in = smf_pkg::KIND_TIMESIG;
                  oa_in = {16'd0, gath_ff[15:8]};
                  ob_in = 8'd1 << gath_ff[2:0];
               end
            end
            smf_pkg::PH_KS_SIG: begin
               gath_in = {16'd0, b}; phase_in = smf_pkg::PH_KS_MAJ;
            end
            smf_pkg::PH_KS_MAJ: begin
               if ($signed(ksig) >= 8'sd7 || $signed(ksig) <= -8'sd7) begin
                  oerr_in = smf_pkg::ERR_CORRUPT; failed_in = 1'b1;
               end else begin
                  give = 1'b1; okind_in = smf_pkg::KIND_KEYSIG;
                  ob_in = b; okey_in = ksig[3:0];
               end
            end
            default: phase_in = smf_pkg::PH_DELTA;
         endcase

         if (give) begin
            delta_in = 32'd0;
            phase_in = smf_pkg::PH_DELTA;
         end
         left_in = left_dec;
         // A truncated event at the end is an overrun, unless an error came first.
         if (last && (phase_in != smf_pkg::PH_DELTA || vlcnt_in != 3'd0)) begin
            if (!failed_in) oerr_in = smf_pkg::ERR_LENGTH;
            failed_in = 1'b1;
         end
      end
   end

   assign odelta_in = give ? delta_ff : 32'd0;
   assign odone_in  = last;
   assign ov_in     = take && !failed_ff && left_ff != 32'd0 &&
                      (okind_in != smf_pkg::KIND_NONE || oerr_in != smf_pkg::ERR_NONE || last);

   always_ff @(posedge clock) begin
      if (reset || csr_valid) begin
         phase_ff  <= smf_pkg::PH_DELTA;
         status_ff <= 8'd0;
         delta_ff  <= 32'd0;
         vl_ff     <= 32'd0;
         vlcnt_ff  <= 3'd0;
         skip_ff   <= 7'd0;
         meta_ff   <= 8'd0;
         gath_ff   <= 24'd0;
         left_ff   <= reset ? 32'd0 : csr_track_length;
         failed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         delta_ff  <= delta_in;
         vl_ff     <= vl_in;
         vlcnt_ff  <= vlcnt_in;
         skip_ff   <= skip_in;
         meta_ff   <= meta_in;
         gath_ff   <= gath_in;
         left_ff   <= left_in;
         failed_ff <= failed_in;
      end
   end

   // Output register: loads a new word when empty or when the last one leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (!req_stall) begin
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && ov_in) begin
         okind_ff  <= okind_in;
         odelta_ff <= odelta_in;
         ochan_ff  <= ochan_in;
         oa_ff     <= oa_in;
         ob_ff     <= ob_in;
         okey_ff   <= okey_in;
         oerr_ff   <= oerr_in;
         odone_ff  <= odone_in;
      end
   end

   assign rsp_valid      = ov_ff;
   assign rsp_kind       = okind_ff;
   assign rsp_delta_time = odelta_ff;
   assign rsp_channel    = ochan_ff;
   assign rsp_value_a    = oa_ff;
   assign rsp_value_b    = ob_ff;
   assign rsp_key_sharps = okey_ff;
   assign rsp_error_code = oerr_ff;
   assign rsp_track_done = odone_ff;
endmodule

// ===== hw/rtl/smf_checker.sv =====
// Port-level checker for the MIDI track parser, bound to the top level.
// Depends on assert_macros.svh and smf_pkg.
`include "assert_macros.svh"
module smf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_kind,
   input logic [31:0] rsp_delta_time,
   input logic [1:0]  rsp_error_code
);
   // A stalled result word keeps its kind.
   `CHECK_IMPLY(a_hold, clock, reset, rsp_valid && rsp_stall, ##1 $stable(rsp_kind))
   // Input is stalled only while a result waits.
   `CHECK_IMPLY(a_stall, clock, reset, req_stall, rsp_valid)
   // An error word never carries an event.
   `CHECK_IMPLY(a_errkind, clock, reset, rsp_valid && rsp_error_code != smf_pkg::ERR_NONE,
      rsp_kind == smf_pkg::KIND_NONE)
   // A word with no event carries no delta.
   `CHECK_IMPLY(a_nodelta, clock, reset, rsp_valid && rsp_kind == smf_pkg::KIND_NONE,
      rsp_delta_time == 32'd0)
endmodule

bind smf_track_event_parser_top smf_checker u_smf_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
   .rsp_delta_time(rsp_delta_time), .rsp_error_code(rsp_error_code)
);

// ===== tb/sv/smf_track_event_parser_top_tb.sv =====
// Self-checking testbench for the MIDI track body parser smf_track_event_parser_top.
// Depends on smf_pkg and the RTL of the parser; it predicts every result word itself.
// Directed tracks come first, then random tracks and a long result-side hold-off.
module smf_track_event_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // A result word, laid out as the rsp_ ports.
   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] delta_time;
      logic [3:0]  channel;
      logic [23:0] value_a;
      logic [7:0]  value_b;
      logic [3:0]  key_sharps;
      logic [1:0]  error_code;
      logic        track_done;
   } event_word_type;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [31:0] rsp_delta_time;
   logic [3:0]  rsp_channel;
   logic [23:0] rsp_value_a;
   logic [7:0]  rsp_value_b;
   logic signed [3:0] rsp_key_sharps;
   logic [1:0]  rsp_error_code;
   logic        rsp_track_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_track_length = 32'd0;

   smf_track_event_parser_top DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shared run state.
   event_word_type expected_events[$];
   logic [7:0]  track_bytes[$];
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          events_checked = 0;
   int          tracks_played = 0;
   bit          no_gaps = 1'b0;
   bit          hold_request = 1'b0;
   bit          running_ok = 1'b0;

   // Predictor state: a private copy of the parser.
   smf_pkg::phase_type ph;
   logic [7:0]  run_status;
   logic [31:0] delta_acc;
   logic [31:0] vl_value;
   int          vl_count;
   logic [6:0]  skip_count;
   logic [7:0]  meta_id;
   logic [23:0] gathered;
   logic [31:0] length_reg;
   logic [31:0] remaining;
   bit          failed;
   event_word_type pending;

   function automatic void restart_parser();
      ph = smf_pkg::PH_DELTA;
      run_status = 8'd0;
      delta_acc = 32'd0;
      vl_value = 32'd0;
      vl_count = 0;
      skip_count = 7'd0;
      meta_id = 8'd0;
      gathered = 24'd0;
      remaining = length_reg;
      failed = 1'b0;
   endfunction

   // Only the first error of a track is reported.
   function automatic void flag_error(logic [1:0] code);
      if (!failed) pending.error_code = code;
      failed = 1'b1;
   endfunction

   function automatic void emit_event(logic [3:0] kind, logic [3:0] chan, logic [23:0] a,
                                      logic [7:0] b, logic [3:0] key);
      pending.kind = kind;
      pending.delta_time = delta_acc;
      pending.channel = chan;
      pending.value_a = a;
      pending.value_b = b;
      pending.key_sharps = key;
      delta_acc = 32'd0;
      ph = smf_pkg::PH_DELTA;
   endfunction

   function automatic void begin_skip(logic [31:0] n, bit bad);
      if (n == 0) begin
         ph = smf_pkg::PH_DELTA;
         if (bad) flag_error(smf_pkg::ERR_UNKNOWN);
      end else begin
         skip_count = n[6:0];
         ph = bad ? smf_pkg::PH_SKIP_BAD : smf_pkg::PH_SKIP;
      end
   endfunction

   // Adds one byte to a variable-length number; returns 1 when it is complete.
   function automatic bit varlen_add(logic [7:0] b);
      vl_value = (vl_value << 7) + {25'd0, b[6:0]};
      vl_count++;
      if (!b[7]) return 1'b1;
      if (vl_count >= 5) flag_error(smf_pkg::ERR_LENGTH);
      return 1'b0;
   endfunction

   function automatic void meta_length_known(logic [31:0] len);
      case (meta_id)
         8'h2F: ph = smf_pkg::PH_DELTA;
         8'h51: begin
            if (len != 3) flag_error(smf_pkg::ERR_CORRUPT);
            else begin
               gathered = 24'd0;
               skip_count = 7'd3;
               ph = smf_pkg::PH_TEMPO;
            end
         end
         8'h58: begin
            if (len != 4) flag_error(smf_pkg::ERR_CORRUPT);
            else ph = smf_pkg::PH_TS_NUM;
         end
         8'h59: begin
            if (len != 2) flag_error(smf_pkg::ERR_CORRUPT);
            else ph = smf_pkg::PH_KS_SIG;
         end
         default: begin
            if (len >= smf_pkg::TEXT_LIMIT) flag_error(smf_pkg::ERR_LENGTH);
            else begin_skip(len, 1'b0);
         end
      endcase
   endfunction

   function automatic void first_data(logic [7:0] status, logic [7:0] d);
      case (status[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
            gathered = {16'd0, d};
            ph = smf_pkg::PH_DATA2;
         end
         4'hC: emit_event(smf_pkg::KIND_PROGRAM, status[3:0], {16'd0, d}, 8'd0, 4'd0);
         4'hD: emit_event(smf_pkg::KIND_CHAN_PR, status[3:0], {16'd0, d}, 8'd0, 4'd0);
         4'hF: begin
            // System and meta messages cancel running status.
            run_status = 8'd0;
            if (status == 8'hFF) begin
               meta_id = d;
               if (d == 8'h00 || d == 8'h20 || d == 8'h21) ph = smf_pkg::PH_DLEN;
               else begin
                  vl_value = 32'd0;
                  vl_count = 0;
                  ph = smf_pkg::PH_MLEN;
               end
            end else if (d >= 8'd127) flag_error(smf_pkg::ERR_CORRUPT);
            else begin_skip({24'd0, d}, !(status == 8'hF0 || status == 8'hF7));
         end
         default: ph = smf_pkg::PH_DELTA;
      endcase
   endfunction

   function automatic void second_data(logic [7:0] d);
      logic [3:0] chan;
      logic [23:0] a;
      chan = run_status[3:0];
      a = {16'd0, gathered[7:0]};
      case (run_status[7:4])
         4'h8: emit_event(smf_pkg::KIND_NOTE_OFF, chan, a, d, 4'd0);
         4'h9: emit_event((d != 0) ? smf_pkg::KIND_NOTE_ON : smf_pkg::KIND_NOTE_OFF,
                          chan, a, d, 4'd0);
         4'hA: emit_event(smf_pkg::KIND_POLY, chan, a, d, 4'd0);
         4'hB: emit_event(smf_pkg::KIND_CONTROL, chan, a, d, 4'd0);
         4'hE: emit_event(smf_pkg::KIND_BEND, chan, a, d, 4'd0);
         default: ph = smf_pkg::PH_DELTA;
      endcase
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      logic [7:0] want;
      logic [31:0] len;
      logic signed [7:0] sig;
      case (ph)
         smf_pkg::PH_DELTA: begin
            if (varlen_add(b) && !failed) begin
               delta_acc += vl_value;
               vl_value = 32'd0;
               vl_count = 0;
               ph = smf_pkg::PH_STATUS;
            end
         end
         smf_pkg::PH_STATUS: begin
            if (!b[7]) first_data(run_status, b);
            else begin
               run_status = b;
               ph = smf_pkg::PH_DATA1;
            end
         end
         smf_pkg::PH_DATA1: first_data(run_status, b);
         smf_pkg::PH_DATA2: second_data(b);
         smf_pkg::PH_SKIP, smf_pkg::PH_SKIP_BAD: begin
            skip_count = skip_count - 7'd1;
            if (skip_count == 0) begin_skip(0, ph == smf_pkg::PH_SKIP_BAD);
         end
         smf_pkg::PH_DLEN: begin
            want = (meta_id == 8'h00) ? 8'd2 : 8'd1;
            if (b != want) flag_error(smf_pkg::ERR_CORRUPT);
            else begin_skip({24'd0, want}, 1'b0);
         end
         smf_pkg::PH_MLEN: begin
            if (varlen_add(b) && !failed) begin
               len = vl_value;
               vl_value = 32'd0;
               vl_count = 0;
               meta_length_known(len);
            end
         end
         smf_pkg::PH_TEMPO: begin
            gathered = {gathered[15:0], b};
            skip_count = skip_count - 7'd1;
            if (skip_count == 0)
               emit_event(smf_pkg::KIND_TEMPO, 4'd0, gathered, 8'd0, 4'd0);
         end
         smf_pkg::PH_TS_NUM: begin
            gathered = {16'd0, b};
            ph = smf_pkg::PH_TS_DEN;
         end
         smf_pkg::PH_TS_DEN: begin
            if (b >= 8'd5 || gathered[7:0] > 8'd20) flag_error(smf_pkg::ERR_CORRUPT);
            else begin
               gathered = {8'd0, gathered[7:0], b};
               skip_count = 7'd2;
               ph = smf_pkg::PH_TS_REST;
            end
         end
         smf_pkg::PH_TS_REST: begin
            skip_count = skip_count - 7'd1;
            if (skip_count == 0)
               emit_event(smf_pkg::KIND_TIMESIG, 4'd0, {16'd0, gathered[15:8]},
                          8'd1 << gathered[2:0], 4'd0);
         end
         smf_pkg::PH_KS_SIG: begin
            gathered = {16'd0, b};
            ph = smf_pkg::PH_KS_MAJ;
         end
         smf_pkg::PH_KS_MAJ: begin
            sig = gathered[7:0];
            if (sig >= 7 || sig <= -7) flag_error(smf_pkg::ERR_CORRUPT);
            else emit_event(smf_pkg::KIND_KEYSIG, 4'd0, 24'd0, b, sig[3:0]);
         end
         default: ph = smf_pkg::PH_DELTA;
      endcase
   endfunction

   // Works out the result word, if any, that one accepted byte causes.
   function automatic void predict_byte(logic [7:0] b);
      if (failed || remaining == 0) return;
      pending = '0;
      parse_byte(b);
      remaining--;
      if (remaining == 0) begin
         pending.track_done = 1'b1;
         if (ph != smf_pkg::PH_DELTA || vl_count != 0) flag_error(smf_pkg::ERR_LENGTH);
      end
      if (pending.kind != smf_pkg::KIND_NONE || pending.error_code != smf_pkg::ERR_NONE ||
          pending.track_done)
         expected_events.push_back(pending);
   endfunction

   // Idle lengths: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   // Sends one word on the req_ channel; called at a rising edge, returns at its acceptance.
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(b);
      bytes_sent++;
   endtask

   // Lowers valid and waits until every expected word has come out.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_track_length(logic [31:0] len);
      drain();
      csr_valid <= 1'b1;
      csr_track_length <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      length_reg = len;
      restart_parser();
   endtask

   // Plays the gathered bytes as one track whose declared length is off by len_adjust.
   task automatic play_track(int len_adjust);
      write_track_length(track_bytes.size() + len_adjust);
      foreach (track_bytes[i]) send_byte(track_bytes[i]);
      track_bytes.delete();
      tracks_played++;
   endtask

   function automatic void put(logic [7:0] b);
      track_bytes.push_back(b);
   endfunction

   function automatic void put_varlen(logic [27:0] v);
      int n;
      n = 1;
      while (n < 4 && (v >> (7 * n)) != 0) n++;
      for (int i = n - 1; i >= 0; i--) put({i != 0, 7'((v >> (7 * i)) & 28'h7F)});
   endfunction

   function automatic void put_random_delta();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) put(8'h80);
      if (r < 6) put_varlen($urandom_range(0, 127));
      else if (r < 9) put_varlen($urandom_range(0, 20000));
      else put_varlen(28'($urandom()));
   endfunction

   // Appends one well-formed event with random content, now and then plain noise.
   function automatic void put_random_event();
      int pick;
      int len;
      logic [3:0] hi;
      put_random_delta();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         hi = 4'($urandom_range(8, 14));
         if (!(running_ok && $urandom_range(0, 2) == 0)) put({hi, 4'($urandom())});
         put(8'($urandom_range(0, 127)));
         if (hi != 4'hC && hi != 4'hD)
            put(($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 127)));
         running_ok = 1'b1;
         return;
      end
      running_ok = 1'b0;
      if (pick < 62) begin
         put(8'hFF); put(8'h51); put(8'h03);
         repeat (3) put(8'($urandom()));
      end else if (pick < 69) begin
         put(8'hFF); put(8'h58); put(8'h04);
         put(8'($urandom_range(0, 20))); put(8'($urandom_range(0, 4)));
         put(8'($urandom())); put(8'($urandom()));
      end else if (pick < 76) begin
         put(8'hFF); put(8'h59); put(8'h02);
         put(8'($signed($urandom_range(0, 12)) - 6)); put(8'($urandom_range(0, 1)));
      end else if (pick < 83) begin
         put(8'hFF); put(8'($urandom_range(1, 15)));
         len = $urandom_range(0, 12);
         put_varlen(len);
         repeat (len) put(8'($urandom()));
      end else if (pick < 88) begin
         put($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
         len = $urandom_range(0, 10);
         put(8'(len));
         repeat (len) put(8'($urandom()));
      end else if (pick < 93) begin
         case ($urandom_range(0, 2))
            0: begin
               put(8'hFF); put(8'h00); put(8'h02);
               put(8'($urandom())); put(8'($urandom()));
            end
            1: begin put(8'hFF); put(8'h20); put(8'h01); put(8'($urandom())); end
            default: begin put(8'hFF); put(8'h21); put(8'h01); put(8'($urandom())); end
         endcase
      end else if (pick < 96) begin
         put(8'hFF); put(8'h2F); put(8'h00);
      end else begin
         repeat ($urandom_range(1, 4)) put(8'($urandom()));
      end
   endfunction

   // Result side: random stall streaks, plus one long hold-off on request.
   always @(posedge clock) begin
      static int streak = 0;
      static bit streak_stall = 1'b0;
      if (hold_request) begin
         streak = HOLD_CYCLES;
         streak_stall = 1'b1;
         hold_request = 1'b0;
      end else if (streak == 0) begin
         streak_stall = no_gaps ? 1'b0 : ($urandom_range(0, 2) == 0);
         streak = pick_gap() + 1;
      end
      rsp_stall <= streak_stall;
      streak--;
   end

   // Compares each accepted result word with the oldest expected one.
   always @(posedge clock) begin
      event_word_type got;
      event_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_kind, rsp_delta_time, rsp_channel, rsp_value_a, rsp_value_b,
                rsp_key_sharps, rsp_error_code, rsp_track_done};
         if (expected_events.size() == 0) begin
            $display("%0t: result word with nothing expected: %p", $realtime, got);
            fail_count++;
         end else begin
            want = expected_events.pop_front();
            events_checked++;
            if (got !== want) begin
               $display("%0t: result mismatch expected %p actual %p", $realtime, want, got);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      static int cycles = 0;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $realtime, CYCLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_channel_messages();
      put(8'h00); put(8'h80); put(8'h00); put(8'h7F);        // note off, channel 0
      put(8'h7F); put(8'h9F); put(8'h7F); put(8'h00);        // velocity 0 becomes note off
      put(8'h01); put(8'h40); put(8'h7F);                    // running status note on
      put(8'h00); put(8'hA5); put(8'h10); put(8'h20);
      put(8'h00); put(8'hB3); put(8'h07); put(8'h64);
      put(8'h00); put(8'hCF); put(8'h7F);
      put(8'h00); put(8'hD0); put(8'h00);
      put(8'h00); put(8'hE8); put(8'h7F); put(8'h7F);
      play_track(0);
   endtask

   task automatic test_meta_events();
      put(8'h81); put(8'h00); put(8'hFF); put(8'h51); put(8'h03);
      put(8'hFF); put(8'hFF); put(8'hFF);
      put(8'h00); put(8'hFF); put(8'h58); put(8'h04);
      put(8'd20); put(8'd4); put(8'h18); put(8'h08);
      put(8'h05); put(8'hFF); put(8'h01); put(8'h02); put(8'h41); put(8'h42);  // text is skipped
      put(8'h00); put(8'hFF); put(8'h59); put(8'h02); put(8'hFA); put(8'h01);
      put(8'h00); put(8'hFF); put(8'h59); put(8'h02); put(8'h06); put(8'h00);
      put(8'h00); put(8'hFF); put(8'h2F); put(8'h00);
      play_track(0);
   endtask

   // Each error case gets a track of its own, since errors are sticky.
   task automatic test_error_cases();
      // Delta number of five bytes, the last still continued.
      repeat (5) put(8'hFF);
      play_track(3);
      // Sysex length at the limit.
      put(8'h00); put(8'hF0); put(8'd127);
      play_track(0);
      // Unknown system status with length zero, then after a skip.
      put(8'h00); put(8'hF1); put(8'h00);
      play_track(2);
      put(8'h00); put(8'hF4); put(8'h02); put(8'h11); put(8'h22);
      play_track(0);
      // Data meta with a wrong length byte.
      put(8'h00); put(8'hFF); put(8'h20); put(8'h02);
      play_track(0);
      // Text meta too long.
      put(8'h00); put(8'hFF); put(8'h03); put(8'd100);
      play_track(0);
      // Tempo, time and key signature with bad lengths or values.
      put(8'h00); put(8'hFF); put(8'h51); put(8'h02);
      play_track(0);
      put(8'h00); put(8'hFF); put(8'h58); put(8'h04); put(8'd21); put(8'd2);
      play_track(0);
      put(8'h00); put(8'hFF); put(8'h58); put(8'h04); put(8'd4); put(8'd5);
      play_track(0);
      put(8'h00); put(8'hFF); put(8'h59); put(8'h02); put(8'hF9); put(8'h00);
      play_track(0);
      // Data byte with no running status, then a track cut off mid event.
      put(8'h05); put(8'h40); put(8'h03); put(8'h90); put(8'h3C);
      play_track(0);
      // Empty track: every byte is dropped.
      put(8'h00); put(8'h90);
      play_track(-2);
   endtask

   task automatic test_random_tracks();
      int target;
      int adj;
      target = bytes_sent + 1000;
      while (bytes_sent < target) begin
         no_gaps = ($urandom_range(0, 5) == 0);
         running_ok = 1'b0;
         repeat ($urandom_range(3, 30)) put_random_event();
         adj = $urandom_range(0, 9);
         if (adj < 6) play_track(0);
         else if (adj < 8) play_track(-$urandom_range(1, 3));
         else if (adj < 9) begin
            repeat ($urandom_range(1, 6)) put(8'($urandom()));
            play_track(0);
         end else begin
            write_track_length(32'hFFFF_FFFF);
            foreach (track_bytes[i]) send_byte(track_bytes[i]);
            track_bytes.delete();
            tracks_played++;
         end
      end
      no_gaps = 1'b0;
   endtask

   // Holds the result side off while the sender keeps offering dense events.
   task automatic test_result_hold_off();
      running_ok = 1'b0;
      repeat (40) begin
         put(8'h00); put(8'h91);
         put(8'($urandom_range(0, 127))); put(8'($urandom_range(1, 127)));
      end
      write_track_length(track_bytes.size());
      hold_request = 1'b1;
      no_gaps = 1'b1;
      foreach (track_bytes[i]) send_byte(track_bytes[i]);
      track_bytes.delete();
      tracks_played++;
      no_gaps = 1'b0;
   endtask

   initial begin
      length_reg = 32'd0;
      restart_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_channel_messages();
      test_meta_events();
      test_error_cases();
      test_random_tracks();
      test_result_hold_off();
      write_track_length(32'd0);
      drain();
      $display("Covered %0d tracks and %0d bytes; %0d result words checked.",
               tracks_played, bytes_sent, events_checked);
      $display("Channel, meta, sysex, error, truncation and hold-off cases were included.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
